### rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, cond, prop)

`define ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

### rtl/htb_pkg.sv
`default_nettype none

package htb_pkg;

  localparam int COLUMN_BITS = 16;
  localparam int LINE_BITS   = 24;
  localparam int DIGIT_BITS  = 32;
  localparam int WINDOW_BITS = 10;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_COLUMN = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LAST_COLUMN  = 2'd1;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;
  localparam logic [1:0] KIND_OK    = 2'd2;
  localparam logic [1:0] KIND_ODD   = 2'd3;

  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] HEX_TEN    = 8'd10;

  typedef struct packed {
    logic       operation;
    logic [7:0] char_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]             result_kind;
    logic [7:0]             data_byte;
    logic [LINE_BITS-1:0]   line_number;
    logic [COLUMN_BITS-1:0] column_number;
    logic [DIGIT_BITS-1:0]  digit_total;
  } result_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_decode(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      r = {1'b1, 4'(c - CHAR_0)};
    end else if (c >= CHAR_UA && c <= CHAR_UF) begin
      r = {1'b1, 4'(c - CHAR_UA + HEX_TEN)};
    end else if (c >= CHAR_LA && c <= CHAR_LF) begin
      r = {1'b1, 4'(c - CHAR_LA + HEX_TEN)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/htb_core.sv
`default_nettype none

module htb_core
  import htb_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [WINDOW_BITS-1:0]    cfg_data,
  input  wire item_t                     item,
  input  wire logic                      step,
  output logic                           emit,
  output result_t                        result
);

  logic [WINDOW_BITS-1:0] first_column;
  logic [WINDOW_BITS-1:0] last_column;
  logic [COLUMN_BITS-1:0] column_count, column_count_next;
  logic [LINE_BITS-1:0]   line_count, line_count_next;
  logic [DIGIT_BITS-1:0]  digit_count, digit_count_next;
  logic [3:0]             high_nibble, high_nibble_next;
  logic                   halted, halted_next;

  logic [COLUMN_BITS-1:0] first_ext, last_ext, column_inc;
  logic [LINE_BITS-1:0]   line_inc;
  logic [DIGIT_BITS-1:0]  digit_inc;
  logic                   is_ws, in_window;
  logic [4:0]             hex;

  always_comb begin
    first_ext  = COLUMN_BITS'(first_column);
    last_ext   = COLUMN_BITS'(last_column);
    column_inc = (column_count == '1) ? column_count : column_count + 1'b1;
    line_inc   = (line_count == '1) ? line_count : line_count + 1'b1;
    digit_inc  = (digit_count == '1) ? digit_count : digit_count + 1'b1;
    is_ws      = (item.char_byte >= CHAR_TAB && item.char_byte <= CHAR_CR)
                 || item.char_byte == CHAR_SPACE;
    hex        = hex_decode(item.char_byte);
    if (first_column < last_column) begin
      in_window = column_count >= first_ext && column_count <= last_ext;
    end else if (first_column > last_column) begin
      in_window = column_count >= first_ext || column_count <= last_ext;
    end else begin
      in_window = 1'b1;
    end

    column_count_next = column_count;
    line_count_next   = line_count;
    digit_count_next  = digit_count;
    high_nibble_next  = high_nibble;
    halted_next       = halted;
    emit              = 1'b0;
    result            = '0;

    if (item.operation == OP_END) begin
      emit                 = !halted;
      result.result_kind   = digit_count[0] ? KIND_ODD : KIND_OK;
      result.digit_total   = digit_count;
      column_count_next    = COLUMN_BITS'(1);
      line_count_next      = LINE_BITS'(1);
      digit_count_next     = '0;
      high_nibble_next     = '0;
      halted_next          = 1'b0;
    end else if (halted) begin
      emit = 1'b0;
    end else if (item.char_byte == CHAR_NL) begin
      column_count_next = COLUMN_BITS'(1);
      line_count_next   = line_inc;
    end else if (is_ws || !in_window) begin
      column_count_next = column_inc;
    end else if (!hex[4]) begin
      emit                 = 1'b1;
      result.result_kind   = KIND_ERROR;
      result.data_byte     = item.char_byte;
      result.line_number   = line_count;
      result.column_number = column_count;
      result.digit_total   = digit_count;
      halted_next          = 1'b1;
    end else begin
      digit_count_next  = digit_inc;
      column_count_next = column_inc;
      if (digit_count[0]) begin
        emit                 = 1'b1;
        result.result_kind   = KIND_DATA;
        result.data_byte     = {high_nibble, hex[3:0]};
        result.line_number   = line_count;
        result.column_number = column_count;
        result.digit_total   = digit_inc;
        high_nibble_next     = '0;
      end else begin
        high_nibble_next = hex[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_column <= '0;
      last_column  <= '0;
      column_count <= COLUMN_BITS'(1);
      line_count   <= LINE_BITS'(1);
      digit_count  <= '0;
      high_nibble  <= '0;
      halted       <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_FIRST_COLUMN) begin
          first_column <= cfg_data;
        end else if (cfg_index == REG_LAST_COLUMN) begin
          last_column <= cfg_data;
        end
      end
      if (step) begin
        column_count <= column_count_next;
        line_count   <= line_count_next;
        digit_count  <= digit_count_next;
        high_nibble  <= high_nibble_next;
        halted       <= halted_next;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/hex_text_to_binary_stream.sv
// Hex text to binary converter. Takes one source character per transfer and
// turns each pair of hex digits into a byte; reports the first unexpected
// character in the column window with its line and column, and reports
// success or an odd digit count at end of source when no error came before.
// Sustains one character per cycle while no result is held back: an input
// register feeds a single decode stage that updates the line, column and
// digit counters and loads the result register. A character that yields a
// result waits in the input register while the result register is still full.
// Configuration writes are taken at any time but must only be issued while
// the block is idle.
`default_nettype none

`include "assert_macros.svh"

module hex_text_to_binary_stream
  import htb_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      operation,
  input  wire logic [7:0]                char_byte,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [1:0]                     result_kind,
  output logic [7:0]                     data_byte,
  output logic [LINE_BITS-1:0]           line_number,
  output logic [COLUMN_BITS-1:0]         column_number,
  output logic [DIGIT_BITS-1:0]          digit_total,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [WINDOW_BITS-1:0]    cfg_data
);

  item_t   item;
  logic    in_full;
  logic    emit;
  logic    fire;
  logic    out_free;
  result_t result;
  result_t out_reg;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign fire      = in_full && (!emit || out_free);
  assign in_ready  = !in_full || fire;

  htb_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .step      (fire),
    .emit      (emit),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.operation <= operation;
      item.char_byte <= char_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_reg <= result;
    end
  end

  assign result_kind   = out_reg.result_kind;
  assign data_byte     = out_reg.data_byte;
  assign line_number   = out_reg.line_number;
  assign column_number = out_reg.column_number;
  assign digit_total   = out_reg.digit_total;

  `ASSERT_NEXT(a_emit_loads_out, clk, rst, fire && emit, out_valid)
  `ASSERT_IMPLY(a_end_no_position, clk, rst,
    out_valid && (result_kind == KIND_OK || result_kind == KIND_ODD),
    line_number == '0 && column_number == '0 && data_byte == '0)
  `ASSERT_IMPLY(a_end_kind_parity, clk, rst,
    out_valid && (result_kind == KIND_OK || result_kind == KIND_ODD),
    digit_total[0] == (result_kind == KIND_ODD))
  `ASSERT_IMPLY(a_data_even_total, clk, rst,
    out_valid && result_kind == KIND_DATA,
    digit_total[0] == 1'b0 || digit_total == '1)

endmodule

`default_nettype wire

### bench/tb_hex_text_to_binary_stream.sv
`timescale 1ns / 100ps

module tb_hex_text_to_binary_stream;
  import htb_pkg::*;

  localparam int LATENCY_SLACK = 4;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_COUNT   = 7;
  localparam int PHASE_ITEMS   = 120;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

  localparam logic [7:0] CHAR_VT   = 8'h0B;
  localparam logic [7:0] CHAR_FF   = 8'h0C;
  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] CHAR_HIGH = 8'h80;
  localparam logic [7:0] CHAR_TOP  = 8'hFF;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  logic                      operation = OP_CHAR;
  logic [7:0]                char_byte = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [1:0]                result_kind;
  logic [7:0]                data_byte;
  logic [LINE_BITS-1:0]      line_number;
  logic [COLUMN_BITS-1:0]    column_number;
  logic [DIGIT_BITS-1:0]     digit_total;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [WINDOW_BITS-1:0]    cfg_data  = '0;

  item_t   pending_items[$];
  result_t expected_results[$];

  int staged_items       = 0;
  int error_count        = 0;
  int stalled_cycles     = 0;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;

  int phase_first [PHASE_COUNT] = '{0, 3, 20, 0, 1023, 190, 7};
  int phase_last  [PHASE_COUNT] = '{0, 20, 3, 1023, 0, 512, 7};

  logic [WINDOW_BITS-1:0] window_first = '0;
  logic [WINDOW_BITS-1:0] window_last  = '0;
  logic [COLUMN_BITS-1:0] column_pos   = 1;
  logic [LINE_BITS-1:0]   line_pos     = 1;
  logic [DIGIT_BITS-1:0]  digits_seen  = '0;
  logic [3:0]             high_nibble  = '0;
  logic                   halted       = 1'b0;

  hex_text_to_binary_stream i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .char_byte    (char_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .data_byte    (data_byte),
    .line_number  (line_number),
    .column_number(column_number),
    .digit_total  (digit_total),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic predict_result(input logic op, input logic [7:0] c);
    result_t    r;
    logic       kept;
    logic       is_hex;
    logic [7:0] nib;
    logic       was_odd;
    r = '0;
    if (op == OP_END) begin
      if (!halted) begin
        r.result_kind = digits_seen[0] ? KIND_ODD : KIND_OK;
        r.digit_total = digits_seen;
        expected_results.push_back(r);
      end
      column_pos  = 1;
      line_pos    = 1;
      digits_seen = '0;
      high_nibble = '0;
      halted      = 1'b0;
    end else if (!halted) begin
      if (window_first < window_last) begin
        kept = column_pos >= window_first && column_pos <= window_last;
      end else if (window_first > window_last) begin
        kept = column_pos >= window_first || column_pos <= window_last;
      end else begin
        kept = 1'b1;
      end
      is_hex = 1'b1;
      nib = '0;
      if (c >= CHAR_0 && c <= CHAR_9) begin
        nib = c - CHAR_0;
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
        nib = c - CHAR_UA + HEX_TEN;
      end else if (c >= CHAR_LA && c <= CHAR_LF) begin
        nib = c - CHAR_LA + HEX_TEN;
      end else begin
        is_hex = 1'b0;
      end
      if (c == CHAR_NL) begin
        column_pos = 1;
        if (line_pos != '1) line_pos = line_pos + 1;
      end else if ((c >= CHAR_TAB && c <= CHAR_CR) || c == CHAR_SPACE || !kept) begin
        if (column_pos != '1) column_pos = column_pos + 1;
      end else if (!is_hex) begin
        r.result_kind   = KIND_ERROR;
        r.data_byte     = c;
        r.line_number   = line_pos;
        r.column_number = column_pos;
        r.digit_total   = digits_seen;
        expected_results.push_back(r);
        halted = 1'b1;
      end else begin
        was_odd = digits_seen[0];
        r.column_number = column_pos;
        if (digits_seen != '1) digits_seen = digits_seen + 1;
        if (column_pos != '1) column_pos = column_pos + 1;
        if (!was_odd) begin
          high_nibble = nib[3:0];
        end else begin
          r.result_kind = KIND_DATA;
          r.data_byte   = {high_nibble, nib[3:0]};
          r.line_number = line_pos;
          r.digit_total = digits_seen;
          expected_results.push_back(r);
          high_nibble = '0;
        end
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  function automatic void stage_item(input logic op, input logic [7:0] c);
    item_t it;
    it.operation = op;
    it.char_byte = c;
    pending_items.push_back(it);
    staged_items++;
  endfunction

  task automatic add_random_source(input int min_len, input int max_len,
                                   input int newline_pct, input int noisy_pct);
    int   roll;
    int   value;
    logic noisy;
    noisy = $urandom_range(0, 99) < noisy_pct;
    repeat ($urandom_range(min_len, max_len)) begin
      roll  = $urandom_range(0, 99);
      value = $urandom_range(0, 15);
      if (noisy && roll < 8) begin
        stage_item(OP_CHAR, 8'($urandom_range(0, 255)));
      end else if (roll >= 100 - newline_pct) begin
        stage_item(OP_CHAR, CHAR_NL);
      end else if (roll >= 88 - newline_pct) begin
        stage_item(OP_CHAR, $urandom_range(0, 1) ? CHAR_SPACE
                                                 : 8'($urandom_range(CHAR_TAB, CHAR_CR)));
      end else if (value < HEX_TEN) begin
        stage_item(OP_CHAR, CHAR_0 + 8'(value));
      end else begin
        stage_item(OP_CHAR, ($urandom_range(0, 1) ? CHAR_UA : CHAR_LA) + 8'(value) - HEX_TEN);
      end
    end
    stage_item(OP_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (LATENCY_SLACK) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [WINDOW_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FIRST_COLUMN: window_first = val;
      REG_LAST_COLUMN:  window_last  = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin : feed_items
    item_t next_item;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_result(operation, char_byte);
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          next_item = pending_items.pop_front();
          in_valid  <= 1'b1;
          operation <= next_item.operation;
          char_byte <= next_item.char_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected, expected nothing actual kind %0d data %0h",
                   $time, result_kind, data_byte);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("result_kind", 32'(want.result_kind), 32'(result_kind));
          compare_field("data_byte", 32'(want.data_byte), 32'(data_byte));
          compare_field("line_number", 32'(want.line_number), 32'(line_number));
          compare_field("column_number", 32'(want.column_number), 32'(column_number));
          compare_field("digit_total", 32'(want.digit_total), 32'(digit_total));
        end
      end
      out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin : run_phases
    int target;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    sender_idle_pct    = 29;
    receiver_stall_pct = 55;

    stage_item(OP_CHAR, CHAR_0);
    stage_item(OP_CHAR, CHAR_9);
    stage_item(OP_CHAR, CHAR_SPACE);
    stage_item(OP_CHAR, CHAR_UA);
    stage_item(OP_CHAR, CHAR_UF);
    stage_item(OP_CHAR, CHAR_TAB);
    stage_item(OP_CHAR, CHAR_LA);
    stage_item(OP_CHAR, CHAR_LF);
    stage_item(OP_CHAR, CHAR_NL);
    stage_item(OP_CHAR, CHAR_VT);
    stage_item(OP_CHAR, CHAR_FF);
    stage_item(OP_CHAR, CHAR_CR);
    stage_item(OP_CHAR, CHAR_UF);
    stage_item(OP_CHAR, CHAR_0);
    stage_item(OP_CHAR, CHAR_9);
    stage_item(OP_END, CHAR_NUL);
    stage_item(OP_CHAR, CHAR_NUL);
    stage_item(OP_CHAR, CHAR_0);
    stage_item(OP_END, CHAR_0);
    stage_item(OP_CHAR, CHAR_9);
    stage_item(OP_CHAR, CHAR_LA);
    stage_item(OP_CHAR, CHAR_TOP);
    stage_item(OP_END, CHAR_TOP);
    stage_item(OP_END, CHAR_TOP);
    stage_item(OP_CHAR, CHAR_HIGH);
    stage_item(OP_END, CHAR_HIGH);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_drained();
      write_register(REG_FIRST_COLUMN, WINDOW_BITS'(phase_first[p]));
      write_register(REG_LAST_COLUMN, WINDOW_BITS'(phase_last[p]));
      write_register(REG_SPARE, WINDOW_BITS'($urandom));
      if (p < 3) begin
        sender_idle_pct    = 29;
        receiver_stall_pct = 55;
      end else if (p < 5) begin
        sender_idle_pct    = 55;
        receiver_stall_pct = 29;
      end else begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
      end
      target = staged_items + PHASE_ITEMS;
      if (p == 5) add_random_source(220, 240, 0, 0);
      while (staged_items < target) begin
        add_random_source(1, 40, $urandom_range(0, 12), 30);
      end
    end

    wait_drained();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
